// ===== design/dmp_pkg.sv =====
// shared widths, register indexes, reset values and interface structs of the wheel controller
package dmp_pkg;

    localparam int CNT_W     = 16;
    localparam int DRV_W     = 8;
    localparam int INTEG_W   = 23;
    localparam int DIV_W     = 16;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int LSUM_W    = INTEG_W + 1;
    localparam int RSUM_W    = INTEG_W + 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_DIV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_DIV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_DIV = 2'd2;

    // register reset values and fixed law constants
    localparam int PROP_DIV_RST   = 1;
    localparam int INTEG_DIV_RST  = 2500;
    localparam int DERIV_DIV_RST  = 2;
    localparam int INTEG_CLAMP_MUL = 100;
    localparam int DRIVE_MAX      = 255;

    // request to the serial divider
    typedef struct packed {
        logic               start;
        logic [INTEG_W-1:0] dividend;
        logic [DIV_W-1:0]   divisor;
        logic [STEP_W-1:0]  steps;
    } t_div_req;

    // answer from the serial divider
    typedef struct packed {
        logic               done;
        logic [INTEG_W-1:0] quotient;
    } t_div_rsp;

    // divisors as used by the law, plus the integral clamp
    typedef struct packed {
        logic [DIV_W-1:0]   kp;
        logic [DIV_W-1:0]   ki;
        logic [DIV_W-1:0]   kd;
        logic [INTEG_W-1:0] lim;
    } t_gains;

endpackage

// ===== design/dual_motor_position_pid.sv =====
// Two-wheel move-to-target controller. A move transaction (func 1) produces no result;
// a control tick while idle is dropped. A control tick while running produces one
// result, and the input is ready again once that result enters the output register:
// first the errors and integrals are formed, then five divisions (left P and I, right
// P, I and D) run on one shared bit-serial divider that yields one quotient bit per
// cycle, 16 or 23 bits each, then the drives are saturated. The result sits in an output
// register, so a new transaction is accepted while the last result waits. Configuration
// writes are taken every cycle.
module dual_motor_position_pid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dmp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmp_pkg::DIV_W-1:0]     i_cfg_data,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [dmp_pkg::CNT_W-1:0]     i_left_count,
    input  logic [dmp_pkg::CNT_W-1:0]     i_right_count,
    input  logic                          i_left_dir_req,
    input  logic                          i_right_dir_req,
    input  logic [dmp_pkg::CNT_W-1:0]     i_left_goal,
    input  logic [dmp_pkg::CNT_W-1:0]     i_right_goal,
    // result items
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dmp_pkg::DRV_W-1:0]     o_left_drive,
    output logic [dmp_pkg::DRV_W-1:0]     o_right_drive,
    output logic                          o_left_dir_out,
    output logic                          o_right_dir_out,
    output logic                          o_active
);
    import dmp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DIV_REQ,
        S_DIV_WAIT,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        OP_L_P,
        OP_L_I,
        OP_R_P,
        OP_R_I,
        OP_R_D
    } t_op;

    localparam int PAD_W = INTEG_W - CNT_W;

    t_gains   w_gains;
    t_div_req w_req;
    t_div_rsp w_rsp;

    t_state r_state;
    t_op    r_op;
    logic   r_running;
    logic   r_out_valid;

    // wheel state
    logic [CNT_W-1:0]   r_l_target;
    logic [CNT_W-1:0]   r_r_target;
    logic               r_l_dir;
    logic               r_r_dir;
    logic [INTEG_W-1:0] r_l_integ;
    logic [INTEG_W-1:0] r_r_integ;
    logic [CNT_W-1:0]   r_l_last;
    logic [CNT_W-1:0]   r_r_last;

    // per-tick working values
    logic [CNT_W-1:0]   r_l_count;
    logic [CNT_W-1:0]   r_r_count;
    logic               r_l_done;
    logic               r_r_done;
    logic [CNT_W-1:0]   r_l_err;
    logic [CNT_W-1:0]   r_r_err;
    logic               r_d_neg;
    logic [CNT_W-1:0]   r_d_mag;
    logic [LSUM_W-1:0]  r_lsum;
    logic signed [RSUM_W-1:0] r_rsum;

    // output register
    logic [DRV_W-1:0]   r_o_left_drive;
    logic [DRV_W-1:0]   r_o_right_drive;
    logic               r_o_left_dir;
    logic               r_o_right_dir;
    logic               r_o_active;

    logic               w_l_done;
    logic               w_r_done;
    logic [CNT_W-1:0]   w_l_err;
    logic [CNT_W-1:0]   w_r_err;
    logic [INTEG_W-1:0] w_l_integ;
    logic [INTEG_W-1:0] w_r_integ;
    logic [CNT_W:0]     w_d;
    logic [CNT_W:0]     w_d_neg;
    logic [CNT_W-1:0]   w_d_mag;
    logic signed [RSUM_W-1:0] w_q_ext;
    logic [DRV_W-1:0]   w_l_drive;
    logic [DRV_W-1:0]   w_r_drive;
    logic               w_in_take;
    logic               w_out_free;
    logic               w_out_load;

    // integral plus error, clamped at the limit
    function automatic logic [INTEG_W-1:0] integ_next(
        input logic [INTEG_W-1:0] integ,
        input logic [CNT_W-1:0]   err,
        input logic [INTEG_W-1:0] lim
    );
        logic [INTEG_W:0] s;
        s = {1'b0, integ} + (INTEG_W + 1)'(err);
        if (s > {1'b0, lim}) begin
            integ_next = lim;
        end else begin
            integ_next = s[INTEG_W-1:0];
        end
    endfunction

    dmp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gains     (w_gains)
    );

    dmp_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // errors and integrals of both wheels, and the error change of the right wheel
    always_comb begin
        w_l_done  = (r_l_count >= r_l_target);
        w_r_done  = (r_r_count >= r_r_target);
        w_l_err   = r_l_target - r_l_count;
        w_r_err   = r_r_target - r_r_count;
        w_l_integ = integ_next(r_l_integ, w_l_err, w_gains.lim);
        w_r_integ = integ_next(r_r_integ, w_r_err, w_gains.lim);
        w_d       = {1'b0, w_r_err} - {1'b0, r_r_last};
        w_d_neg   = -w_d;
        w_d_mag   = w_d[CNT_W] ? w_d_neg[CNT_W-1:0] : w_d[CNT_W-1:0];
    end

    // divider operand selection for the current division
    always_comb begin
        w_req.start = (r_state == S_DIV_REQ);
        unique case (r_op)
            OP_L_P: begin
                w_req.dividend = {r_l_err, {PAD_W{1'b0}}};
                w_req.divisor  = w_gains.kp;
                w_req.steps    = STEP_W'(CNT_W);
            end
            OP_L_I: begin
                w_req.dividend = r_l_integ;
                w_req.divisor  = w_gains.ki;
                w_req.steps    = STEP_W'(INTEG_W);
            end
            OP_R_P: begin
                w_req.dividend = {r_r_err, {PAD_W{1'b0}}};
                w_req.divisor  = w_gains.kp;
                w_req.steps    = STEP_W'(CNT_W);
            end
            OP_R_I: begin
                w_req.dividend = r_r_integ;
                w_req.divisor  = w_gains.ki;
                w_req.steps    = STEP_W'(INTEG_W);
            end
            OP_R_D: begin
                w_req.dividend = {r_d_mag, {PAD_W{1'b0}}};
                w_req.divisor  = w_gains.kd;
                w_req.steps    = STEP_W'(CNT_W);
            end
            default: begin
                w_req.dividend = '0;
                w_req.divisor  = w_gains.kp;
                w_req.steps    = STEP_W'(CNT_W);
            end
        endcase
    end

    // drive saturation
    always_comb begin
        w_q_ext = $signed({2'b00, w_rsp.quotient});
        if (r_l_done) begin
            w_l_drive = '0;
        end else if (r_lsum > LSUM_W'(DRIVE_MAX)) begin
            w_l_drive = DRV_W'(DRIVE_MAX);
        end else begin
            w_l_drive = r_lsum[DRV_W-1:0];
        end
        if (r_r_done || r_rsum[RSUM_W-1]) begin
            w_r_drive = '0;
        end else if (r_rsum > RSUM_W'(DRIVE_MAX)) begin
            w_r_drive = DRV_W'(DRIVE_MAX);
        end else begin
            w_r_drive = r_rsum[DRV_W-1:0];
        end
    end

    assign w_in_take  = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_out_load = (r_state == S_FINISH) && w_out_free;

    // tick sequencer, wheel state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_L_P;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
            r_l_target  <= '0;
            r_r_target  <= '0;
            r_l_dir     <= 1'b0;
            r_r_dir     <= 1'b0;
            r_l_integ   <= '0;
            r_r_integ   <= '0;
            r_l_last    <= '0;
            r_r_last    <= '0;
        end else begin
            // a new result takes the register as the old one leaves
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        if (i_func) begin
                            // move command
                            if (i_left_goal != '0) begin
                                r_l_dir    <= i_left_dir_req;
                                r_l_target <= i_left_goal;
                                r_l_last   <= i_left_goal;
                            end
                            if (i_right_goal != '0) begin
                                r_r_dir    <= i_right_dir_req;
                                r_r_target <= i_right_goal;
                                r_r_last   <= i_right_goal;
                            end
                            if (i_left_goal != '0 || i_right_goal != '0) begin
                                r_running <= 1'b1;
                            end
                        end else if (r_running) begin
                            r_l_count <= i_left_count;
                            r_r_count <= i_right_count;
                            r_state   <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    r_l_done  <= w_l_done;
                    r_r_done  <= w_r_done;
                    r_l_err   <= w_l_err;
                    r_r_err   <= w_r_err;
                    r_l_integ <= w_l_done ? '0 : w_l_integ;
                    r_r_integ <= w_r_done ? '0 : w_r_integ;
                    if (!w_l_done) begin
                        r_l_last <= w_l_err;
                    end
                    if (!w_r_done) begin
                        r_r_last <= w_r_err;
                    end
                    r_d_neg <= w_d[CNT_W];
                    r_d_mag <= w_d_mag;
                    if (w_l_done && w_r_done) begin
                        r_running <= 1'b0;
                    end
                    r_op    <= OP_L_P;
                    r_state <= S_DIV_REQ;
                end
                S_DIV_REQ: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_rsp.done) begin
                        // gather each quotient into its wheel's sum
                        unique case (r_op)
                            OP_L_P: r_lsum <= LSUM_W'(w_rsp.quotient);
                            OP_L_I: r_lsum <= r_lsum + LSUM_W'(w_rsp.quotient);
                            OP_R_P: r_rsum <= w_q_ext;
                            OP_R_I: r_rsum <= r_rsum + w_q_ext;
                            OP_R_D: r_rsum <= r_d_neg ? r_rsum - w_q_ext : r_rsum + w_q_ext;
                            default: begin
                            end
                        endcase
                        if (r_op == OP_R_D) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_op    <= t_op'(r_op + 3'd1);
                            r_state <= S_DIV_REQ;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_o_left_drive  <= w_l_drive;
                        r_o_right_drive <= w_r_drive;
                        r_o_left_dir    <= r_l_dir;
                        r_o_right_dir   <= r_r_dir;
                        r_o_active      <= r_running;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_left_drive    = r_o_left_drive;
    assign o_right_drive   = r_o_right_drive;
    assign o_left_dir_out  = r_o_left_dir;
    assign o_right_dir_out = r_o_right_dir;
    assign o_active        = r_o_active;

endmodule

// ===== design/dmp_serdiv.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module dmp_serdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dmp_pkg::t_div_req i_req,
    output dmp_pkg::t_div_rsp o_rsp
);
    import dmp_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_cnt;
    logic [INTEG_W-1:0] r_dvd;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_dsr;

    logic [DIV_W+1:0]   w_diff;
    logic               w_qbit;
    logic [DIV_W-1:0]   n_rem;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        w_diff = {1'b0, r_rem, r_dvd[INTEG_W-1]} - {2'b00, r_dsr};
        w_qbit = ~w_diff[DIV_W+1];
        n_rem  = w_qbit ? w_diff[DIV_W-1:0] : {r_rem[DIV_W-2:0], r_dvd[INTEG_W-1]};
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_dvd  <= i_req.dividend;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[INTEG_W-2:0], w_qbit};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule

// ===== design/dmp_cfg.sv =====
// divisor registers with zero substitution and the integral clamp limit
module dmp_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [dmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmp_pkg::DIV_W-1:0]      i_cfg_data,
    output dmp_pkg::t_gains                o_gains
);
    import dmp_pkg::*;

    logic [DIV_W-1:0]   r_kp;
    logic [DIV_W-1:0]   r_ki;
    logic [DIV_W-1:0]   r_kd;
    logic [INTEG_W-1:0] r_lim;

    logic [DIV_W-1:0]   w_eff;
    logic [INTEG_W-1:0] w_lim;

    // a zero divisor divides as one; the clamp keeps the raw value
    always_comb begin
        w_eff = (i_cfg_data == '0) ? DIV_W'(1) : i_cfg_data;
        w_lim = INTEG_W'(i_cfg_data) * INTEG_W'(INTEG_CLAMP_MUL);
    end

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= DIV_W'(PROP_DIV_RST);
            r_ki  <= DIV_W'(INTEG_DIV_RST);
            r_kd  <= DIV_W'(DERIV_DIV_RST);
            r_lim <= INTEG_W'(INTEG_DIV_RST * INTEG_CLAMP_MUL);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP_DIV: begin
                    r_kp <= w_eff;
                end
                CFG_INTEG_DIV: begin
                    r_ki  <= w_eff;
                    r_lim <= w_lim;
                end
                CFG_DERIV_DIV: begin
                    r_kd <= w_eff;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_gains.kp  = r_kp;
    assign o_gains.ki  = r_ki;
    assign o_gains.kd  = r_kd;
    assign o_gains.lim = r_lim;

endmodule

// ===== design/dmp_checker.sv =====
// port-level checks on the wheel controller and their binding to the top level
module dmp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      i_func,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [dmp_pkg::DRV_W-1:0] o_left_drive,
    input logic [dmp_pkg::DRV_W-1:0] o_right_drive,
    input logic                      o_left_dir_out,
    input logic                      o_right_dir_out,
    input logic                      o_active
);
    import dmp_pkg::*;

    // a waiting result holds until its transaction completes
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_left_drive)
            && $stable(o_right_drive) && $stable(o_left_dir_out)
            && $stable(o_right_dir_out) && $stable(o_active))
        else $error("result changed while stalled");

    // once both wheels are home, both drives read zero
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_active |-> o_left_drive == '0 && o_right_drive == '0)
        else $error("nonzero drive with both wheels done");

    // a tick needs the whole division sequence before its result shows
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_func |=> !$rose(o_valid))
        else $error("result appeared one cycle after a tick");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind dual_motor_position_pid dmp_checker u_dmp_checker (.*);

// ===== sim/dual_motor_position_pid_tb.sv =====
// self-checking testbench for the two-wheel position controller
`timescale 1ns / 100ps

typedef enum bit {
    FUNC_TICK = 1'b0,
    FUNC_MOVE = 1'b1
} func_e;

// one input transaction
typedef struct packed {
    func_e       func;
    logic [15:0] left_count;
    logic [15:0] right_count;
    logic        l_dir_req;
    logic        r_dir_req;
    logic [15:0] left_goal;
    logic [15:0] right_goal;
} item_t;

// one result transaction
typedef struct packed {
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic       l_dir_out;
    logic       r_dir_out;
    logic       active;
} drive_t;

// controller state mirror plus the queue of drives still owed by the block
class wheel_drive_board;
    logic [dmp_pkg::DIV_W-1:0]   kp;
    logic [dmp_pkg::DIV_W-1:0]   ki;
    logic [dmp_pkg::DIV_W-1:0]   kd;
    logic [dmp_pkg::CNT_W-1:0]   l_target;
    logic [dmp_pkg::CNT_W-1:0]   r_target;
    logic                        l_dir;
    logic                        r_dir;
    logic [dmp_pkg::INTEG_W-1:0] l_integ;
    logic [dmp_pkg::INTEG_W-1:0] r_integ;
    logic [dmp_pkg::CNT_W-1:0]   l_last;
    logic [dmp_pkg::CNT_W-1:0]   r_last;
    bit                          running;
    drive_t                      expected_drives[$];
    int                          errors;

    function new();
        kp = 16'(dmp_pkg::PROP_DIV_RST);
        ki = 16'(dmp_pkg::INTEG_DIV_RST);
        kd = 16'(dmp_pkg::DERIV_DIV_RST);
        l_target = '0;
        r_target = '0;
        l_dir = 1'b0;
        r_dir = 1'b0;
        l_integ = '0;
        r_integ = '0;
        l_last = '0;
        r_last = '0;
        running = 1'b0;
        errors = 0;
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function int pending();
        return expected_drives.size();
    endfunction

    function void set_gain(logic [dmp_pkg::CFG_IDX_W-1:0] idx, logic [dmp_pkg::DIV_W-1:0] data);
        case (idx)
            dmp_pkg::CFG_PROP_DIV:  kp = data;
            dmp_pkg::CFG_INTEG_DIV: ki = data;
            dmp_pkg::CFG_DERIV_DIV: kd = data;
            default: ;
        endcase
    endfunction

    // a zero divisor behaves as one
    function longint eff_div(logic [dmp_pkg::DIV_W-1:0] d);
        return (d == '0) ? 64'sd1 : longint'(d);
    endfunction

    // one wheel of the control law
    function logic [7:0] wheel_law(input logic [15:0] target, input logic [15:0] count,
                                   inout logic [dmp_pkg::INTEG_W-1:0] integ,
                                   inout logic [15:0] last, input bit with_deriv,
                                   output bit done);
        longint err;
        longint lim;
        longint acc;
        longint sum;
        if (count >= target) begin
            integ = '0;
            done = 1'b1;
            return '0;
        end
        done = 1'b0;
        err = longint'(target) - longint'(count);
        lim = longint'(dmp_pkg::INTEG_CLAMP_MUL) * longint'(ki);
        acc = longint'(integ) + err;
        if (acc > lim)
            acc = lim;
        integ = acc[dmp_pkg::INTEG_W-1:0];
        sum = err / eff_div(kp) + acc / eff_div(ki);
        if (with_deriv)
            sum += (err - longint'(last)) / eff_div(kd);
        last = err[15:0];
        if (sum < 0)
            sum = 0;
        if (sum > dmp_pkg::DRIVE_MAX)
            sum = dmp_pkg::DRIVE_MAX;
        return sum[7:0];
    endfunction

    // update state for an accepted input, queue a drive if one is due
    function void note_item(item_t it);
        drive_t exp;
        bit     l_done;
        bit     r_done;
        if (it.func == FUNC_MOVE) begin
            if (it.left_goal != '0) begin
                l_dir = it.l_dir_req;
                l_target = it.left_goal;
                l_last = it.left_goal;
            end
            if (it.right_goal != '0) begin
                r_dir = it.r_dir_req;
                r_target = it.right_goal;
                r_last = it.right_goal;
            end
            if (it.left_goal != '0 || it.right_goal != '0)
                running = 1'b1;
            return;
        end
        if (!running)
            return;
        exp.left_drive = wheel_law(l_target, it.left_count, l_integ, l_last, 1'b0, l_done);
        exp.right_drive = wheel_law(r_target, it.right_count, r_integ, r_last, 1'b1, r_done);
        if (l_done && r_done)
            running = 1'b0;
        exp.l_dir_out = l_dir;
        exp.r_dir_out = r_dir;
        exp.active = running;
        expected_drives.push_back(exp);
    endfunction

    // compare a delivered drive with the oldest one owed
    task check_drive(drive_t got);
        drive_t exp;
        if (expected_drives.size() == 0) begin
            report("result transaction with nothing expected");
            return;
        end
        exp = expected_drives.pop_front();
        if (got.left_drive !== exp.left_drive)
            report($sformatf("left drive %0d, expected %0d", got.left_drive, exp.left_drive));
        if (got.right_drive !== exp.right_drive)
            report($sformatf("right drive %0d, expected %0d",
                             got.right_drive, exp.right_drive));
        if (got.l_dir_out !== exp.l_dir_out)
            report($sformatf("left dir %b, expected %b", got.l_dir_out, exp.l_dir_out));
        if (got.r_dir_out !== exp.r_dir_out)
            report($sformatf("right dir %b, expected %b", got.r_dir_out, exp.r_dir_out));
        if (got.active !== exp.active)
            report($sformatf("active %b, expected %b", got.active, exp.active));
    endtask
endclass

module dual_motor_position_pid_tb;

    localparam logic [dmp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int TICK_LATENCY = 106;
    localparam int SETTLE_CYCLES = TICK_LATENCY + 20;
    localparam int HOLD_CYCLES = 600;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [dmp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [dmp_pkg::DIV_W-1:0]     i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic                          i_func = 1'b0;
    logic [dmp_pkg::CNT_W-1:0]     i_left_count = '0;
    logic [dmp_pkg::CNT_W-1:0]     i_right_count = '0;
    logic                          i_left_dir_req = 1'b0;
    logic                          i_right_dir_req = 1'b0;
    logic [dmp_pkg::CNT_W-1:0]     i_left_goal = '0;
    logic [dmp_pkg::CNT_W-1:0]     i_right_goal = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [dmp_pkg::DRV_W-1:0]     o_left_drive;
    logic [dmp_pkg::DRV_W-1:0]     o_right_drive;
    logic                          o_left_dir_out;
    logic                          o_right_dir_out;
    logic                          o_active;

    wheel_drive_board wheel_drives;

    int snd_idle = 9;
    int rcv_idle = 67;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int gen_l_tgt = 0;
    int gen_r_tgt = 0;

    dual_motor_position_pid uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_left_count    (i_left_count),
        .i_right_count   (i_right_count),
        .i_left_dir_req  (i_left_dir_req),
        .i_right_dir_req (i_right_dir_req),
        .i_left_goal     (i_left_goal),
        .i_right_goal    (i_right_goal),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_left_drive    (o_left_drive),
        .o_right_drive   (o_right_drive),
        .o_left_dir_out  (o_left_dir_out),
        .o_right_dir_out (o_right_dir_out),
        .o_active        (o_active)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        drive_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.left_drive = o_left_drive;
            got.right_drive = o_right_drive;
            got.l_dir_out = o_left_dir_out;
            got.r_dir_out = o_right_dir_out;
            got.active = o_active;
            wheel_drives.check_drive(got);
        end
    end

    // run limit
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic item_t tick_item(logic [15:0] lc, logic [15:0] rc);
        item_t it;
        it.func = FUNC_TICK;
        it.left_count = lc;
        it.right_count = rc;
        it.l_dir_req = 1'($urandom_range(1));
        it.r_dir_req = 1'($urandom_range(1));
        it.left_goal = 16'($urandom_range(65535));
        it.right_goal = 16'($urandom_range(65535));
        return it;
    endfunction

    function automatic item_t move_item(logic [15:0] lg, logic [15:0] rg, bit ld, bit rd);
        item_t it;
        it.func = FUNC_MOVE;
        it.left_count = 16'($urandom_range(65535));
        it.right_count = 16'($urandom_range(65535));
        it.l_dir_req = ld;
        it.r_dir_req = rd;
        it.left_goal = lg;
        it.right_goal = rg;
        return it;
    endfunction

    // mostly short moves, some long ones
    function automatic int pick_goal();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return $urandom_range(400, 1);
        else if (r < 90)
            return $urandom_range(5000, 1);
        return $urandom_range(65535, 1);
    endfunction

    function automatic int advance_count(int c, int t);
        int step;
        step = $urandom_range(t / 3 + 1, 1);
        return (c + step > 65535) ? 65535 : c + step;
    endfunction

    // one input transaction; returns at the accepting edge
    task automatic push_item(item_t it);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_func <= it.func;
        i_left_count <= it.left_count;
        i_right_count <= it.right_count;
        i_left_dir_req <= it.l_dir_req;
        i_right_dir_req <= it.r_dir_req;
        i_left_goal <= it.left_goal;
        i_right_goal <= it.right_goal;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        wheel_drives.note_item(it);
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (wheel_drives.pending() != 0)
            @(negedge i_clk);
    endtask

    // idle point: all drives delivered and any move still in flight finished
    task automatic quiesce();
        stop_items();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write all three divisors, then a write to the unused index
    task automatic write_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                               logic [15:0] junk);
        logic [dmp_pkg::CFG_IDX_W-1:0] idx [4];
        logic [15:0]                   val [4];
        idx = '{dmp_pkg::CFG_PROP_DIV, dmp_pkg::CFG_INTEG_DIV, dmp_pkg::CFG_DERIV_DIV,
                CFG_UNUSED};
        val = '{kp, ki, kd, junk};
        for (int k = 0; k < 4; k++) begin
            @(negedge i_clk);
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            i_cfg_valid <= 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            wheel_drives.set_gain(idx[k], val[k]);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // field extremes and the corner cases of the law, at reset gains
    task automatic run_directed();
        push_item(tick_item(16'd5, 16'd5));
        push_item(move_item(16'd0, 16'd0, 1'b1, 1'b1));
        push_item(tick_item(16'd0, 16'd0));
        push_item(move_item(16'd1000, 16'd1000, 1'b1, 1'b0));
        push_item(tick_item(16'd0, 16'd0));
        // large count step drives the right sum negative
        push_item(tick_item(16'd990, 16'd990));
        push_item(move_item(16'd0, 16'hFFFF, 1'b0, 1'b1));
        push_item(tick_item(16'd0, 16'hFFFF));
        push_item(tick_item(16'd1000, 16'hFFFF));
        push_item(tick_item(16'hFFFF, 16'd0));
        push_item(move_item(16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
        // integral runs into its clamp
        repeat (5) push_item(tick_item(16'd0, 16'd0));
        push_item(tick_item(16'hFFFE, 16'hFFFE));
        push_item(tick_item(16'hFFFF, 16'hFFFF));
        push_item(move_item(16'd1, 16'd1, 1'b1, 1'b1));
        push_item(tick_item(16'd0, 16'd0));
        push_item(tick_item(16'd1, 16'd0));
        push_item(tick_item(16'd1, 16'd1));
    endtask

    // moves followed by ticks that walk the counts up to the targets, with noise
    task automatic run_motion(int n);
        int          sent;
        int          r;
        int          lc;
        int          rc;
        bit          done;
        logic [15:0] lg;
        logic [15:0] rg;
        item_t       noise;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 12) begin
                noise.func = func_e'($urandom_range(1));
                noise.left_count = 16'($urandom_range(65535));
                noise.right_count = 16'($urandom_range(65535));
                noise.l_dir_req = 1'($urandom_range(1));
                noise.r_dir_req = 1'($urandom_range(1));
                noise.left_goal = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
                noise.right_goal = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
                push_item(noise);
            end else begin
                lg = 16'(pick_goal());
                rg = 16'(pick_goal());
                r = $urandom_range(99);
                if (r < 8)
                    lg = '0;
                else if (r < 16)
                    rg = '0;
                push_item(move_item(lg, rg, 1'($urandom_range(1)), 1'($urandom_range(1))));
                sent++;
                if (lg != '0)
                    gen_l_tgt = lg;
                if (rg != '0)
                    gen_r_tgt = rg;
                lc = 0;
                rc = 0;
                do begin
                    // occasional broken sequence: counts jump anywhere
                    if ($urandom_range(99) < 4) begin
                        lc = $urandom_range(65535);
                        rc = $urandom_range(65535);
                    end
                    push_item(tick_item(16'(lc), 16'(rc)));
                    sent++;
                    done = (lc >= gen_l_tgt) && (rc >= gen_r_tgt);
                    lc = advance_count(lc, gen_l_tgt);
                    rc = advance_count(rc, gen_r_tgt);
                end while (!done);
            end
        end
    endtask

    // main sequence
    initial begin
        wheel_drives = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains, sender lightly idle, receiver mostly stalled
        run_directed();
        run_motion(75);

        // largest divisors, with a long receiver hold-off
        quiesce();
        write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        run_motion(30);
        hold_token++;
        run_motion(60);

        // smallest divisors, roles of the two sides swapped
        quiesce();
        snd_idle = 67;
        rcv_idle = 9;
        write_gains(16'd1, 16'd1, 16'd1, 16'hFFFF);
        run_motion(45);
        stop_items();
        wait_drained();
        run_motion(45);

        // zero divisors
        quiesce();
        write_gains(16'd0, 16'd0, 16'd0, 16'($urandom_range(65535)));
        run_motion(80);

        // small random gains, no idling
        quiesce();
        snd_idle = 0;
        rcv_idle = 0;
        write_gains(16'($urandom_range(20, 1)), 16'($urandom_range(400, 1)),
                    16'($urandom_range(8, 1)), 16'($urandom_range(65535)));
        run_motion(90);

        // full-range random gains
        quiesce();
        write_gains(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                    16'($urandom_range(65535, 1)), 16'($urandom_range(65535)));
        run_motion(80);

        quiesce();
        if (wheel_drives.pending() != 0)
            wheel_drives.report("expected results left over at end of run");
        if (wheel_drives.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/dmp_pkg.sv
design/dmp_serdiv.sv
design/dmp_cfg.sv
design/dual_motor_position_pid.sv
design/dmp_checker.sv
sim/dual_motor_position_pid_tb.sv
